>>> src/huffman_code_bit_packer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman code bit packer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define HCBP_ASSERT(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
		else $error("hcbp assertion failed");
// Condition must never be true at a rising edge outside reset.
`define HCBP_ASSERT_NEVER(lbl, clk_i, rstn_i, cond) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) \
		else $error("hcbp forbidden condition seen");
`else
`define HCBP_ASSERT(lbl, clk_i, rstn_i, prop)
`define HCBP_ASSERT_NEVER(lbl, clk_i, rstn_i, cond)
`endif

`endif

>>> src/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types and constants shared by the Huffman code bit packer modules.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int BYTE_W    = 8;
	localparam int SYM_W     = 8;
	localparam int WORD_BITS = 32;
	localparam int LEN_W     = 6;
	localparam int PEND_W    = 7;
	localparam int PCNT_W    = 3;
	localparam int OUT_BYTES = 4;
	localparam int BCNT_W    = 3;
	localparam int ACC_W     = PEND_W + WORD_BITS;

	// Input transfer layout
	localparam int S_TUSER_W = 2;
	localparam int S_TDATA_W = 48;
	localparam int SYM_LSB   = 0;
	localparam int WORD_LSB  = SYM_LSB + SYM_W;
	localparam int LEN_LSB   = WORD_LSB + WORD_BITS;

	typedef enum logic [S_TUSER_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0]     len;
		logic [WORD_BITS-1:0] word;
	} code_entry_t;

	typedef struct packed {
		logic [OUT_BYTES*BYTE_W-1:0] bytes;     // earliest byte in the top bits
		logic [BCNT_W-1:0]           nbytes;
		logic [PEND_W-1:0]           pend_bits;
		logic [PCNT_W-1:0]           pend_cnt;
	} pack_res_t;

endpackage

>>> src/hcbp_packer.sv
// ----------------------------------------------------------------------------
// hcbp_packer
// Merges one code into the pending bits and splits off the full bytes.
// ----------------------------------------------------------------------------
module hcbp_packer (
	input  logic [hcbp_pkg::PEND_W-1:0]    pend_bits,
	input  logic [hcbp_pkg::PCNT_W-1:0]    pend_cnt,
	input  logic [hcbp_pkg::WORD_BITS-1:0] code_word,
	input  logic [hcbp_pkg::LEN_W-1:0]     code_len,
	output hcbp_pkg::pack_res_t            res
);
	import hcbp_pkg::*;

	logic [ACC_W-1:0] code_mask;
	logic [ACC_W-1:0] merged;
	logic [ACC_W-1:0] rem_mask;
	logic [LEN_W-1:0] total;
	logic [ACC_W:0]   aligned;

	always_comb begin
		code_mask = ~({ACC_W{1'b1}} << code_len);
		merged    = (ACC_W'(pend_bits) << code_len) | (ACC_W'(code_word) & code_mask);
		total     = LEN_W'(pend_cnt) + code_len;
		// left-align so the earliest bit lands in the top bit
		aligned   = {1'b0, merged} << (LEN_W'(ACC_W + 1) - total);
		rem_mask  = ~({ACC_W{1'b1}} << total[PCNT_W-1:0]);

		res.bytes     = aligned[ACC_W -: OUT_BYTES*BYTE_W];
		res.nbytes    = total[LEN_W-1:PCNT_W];
		res.pend_bits = PEND_W'(merged & rem_mask);
		res.pend_cnt  = total[PCNT_W-1:0];
	end

endmodule

>>> src/huffman_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Table-driven Huffman encoder: loads codes into a 256-entry table, packs
// encoded symbols MSB first into bytes and flushes a partial byte on request.
// ----------------------------------------------------------------------------
//
//  channel  | dir | signals                            | carries
//  ---------+-----+------------------------------------+------------------------------
//  s_axis   | in  | tvalid tready tdata[47:0] tuser[1:0]| command, symbol, code, length
//  m_axis   | out | tvalid tready tdata[7:0] tlast     | packed byte, end of item
//
//  An item is accepted every cycle while it yields at most one byte and m_axis
//  does not stall; an item that yields N bytes (up to 4) holds the byte output
//  register until its N bytes have left, one byte per transfer, and the next
//  byte-producing item waits behind it. The first byte of an item passes through
//  the registered code table read and then the pack into the byte register
//  before it appears. Reset clears the pipeline, the pending bits and the byte
//  register count; the code table is not cleared and must be loaded before use.
//  A stall on m_axis fills the single item stage, then drops s_axis_tready.
//
`include "huffman_code_bit_packer_unit_macros.svh"

module huffman_code_bit_packer_unit #(
	parameter int MAX_CODE_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave side
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: symbol[7:0], code_word[39:8], code_length[45:40], zero[47:46]
	input  logic [hcbp_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// tuser: command[1:0]
	input  logic [hcbp_pkg::S_TUSER_W-1:0] s_axis_tuser,
	// master side
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: packed_byte[7:0]
	output logic [hcbp_pkg::BYTE_W-1:0]    m_axis_tdata,
	output logic                            m_axis_tlast
);
	import hcbp_pkg::*;

	// Longest code the table will hold; a code word is 32 bits.
	localparam int LEN_LIMIT = (MAX_CODE_BITS > WORD_BITS) ? WORD_BITS : MAX_CODE_BITS;
	localparam int TBL_DEPTH = 1 << SYM_W;

	// ---------------------------------------------------------------- input
	cmd_t                 in_cmd;
	logic [SYM_W-1:0]     in_sym;
	logic [WORD_BITS-1:0] in_word;
	logic [LEN_W-1:0]     in_len;
	logic [LEN_W-1:0]     in_len_clamped;
	logic                 in_xfer;

	assign in_cmd  = cmd_t'(s_axis_tuser);
	assign in_sym  = s_axis_tdata[SYM_LSB +: SYM_W];
	assign in_word = s_axis_tdata[WORD_LSB +: WORD_BITS];
	assign in_len  = s_axis_tdata[LEN_LSB +: LEN_W];
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// clamp long codes to the table limit
	assign in_len_clamped = (in_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : in_len;

	// ----------------------------------------------------------- code table
	code_entry_t code_mem [TBL_DEPTH];
	code_entry_t rd_s1;
	cmd_t        cmd_s1;
	logic        valid_s1;

	// Write on a load transfer, read on every transfer. A load and an encode
	// never share an edge, so an encode right after a load sees the new entry.
	always_ff @(posedge clk) begin
		if (in_xfer && in_cmd == CMD_LOAD) begin
			code_mem[in_sym] <= '{len: in_len_clamped, word: in_word};
		end
		if (in_xfer) begin
			rd_s1  <= code_mem[in_sym];
			cmd_s1 <= in_cmd;
		end
	end

	// ------------------------------------------------------------ pack step
	logic [PEND_W-1:0]           pend_bits_q;
	logic [PCNT_W-1:0]           pend_cnt_q;
	logic [WORD_BITS-1:0]        sel_word;
	logic [LEN_W-1:0]            sel_len;
	pack_res_t                   pk;

	// A flush with bits pending packs (8 - pending) zero bits, which completes exactly one byte;
	// loads and unused commands pack nothing and leave the pending bits alone.
	always_comb begin
		sel_word = '0;
		sel_len  = '0;
		unique case (cmd_s1)
			CMD_ENCODE: begin
				sel_word = rd_s1.word;
				sel_len  = rd_s1.len;
			end
			CMD_FLUSH: begin
				if (pend_cnt_q != '0) begin
					sel_len = LEN_W'(BYTE_W) - LEN_W'(pend_cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

	hcbp_packer u_packer (
		.pend_bits (pend_bits_q),
		.pend_cnt  (pend_cnt_q),
		.code_word (sel_word),
		.code_len  (sel_len),
		.res       (pk)
	);

	// ----------------------------------------------------- byte output path
	logic [OUT_BYTES*BYTE_W-1:0] buf_q;
	logic [BCNT_W-1:0]           buf_cnt_q;
	logic                        buf_free;
	logic                        adv;
	logic                        load_buf;
	logic                        out_xfer;

	// The byte register takes a new group when it is empty or its last byte
	// leaves in this cycle.
	assign buf_free = (buf_cnt_q == '0) || (buf_cnt_q == BCNT_W'(1) && m_axis_tready);
	// Items that yield no byte advance regardless of the output side.
	assign adv      = valid_s1 && ((pk.nbytes == '0) || buf_free);
	assign load_buf = adv && (pk.nbytes != '0);
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = (buf_cnt_q != '0);
	assign m_axis_tlast  = (buf_cnt_q == BCNT_W'(1));
	assign m_axis_tdata  = buf_q[OUT_BYTES*BYTE_W-1 -: BYTE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			buf_cnt_q   <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				pend_bits_q <= pk.pend_bits;
				pend_cnt_q  <= pk.pend_cnt;
			end
			if (load_buf) begin
				buf_cnt_q <= pk.nbytes;
			end else if (out_xfer) begin
				buf_cnt_q <= buf_cnt_q - BCNT_W'(1);
			end
		end
	end

	// advance the byte queue one byte per transfer
	always_ff @(posedge clk) begin
		if (load_buf) begin
			buf_q <= pk.bytes;
		end else if (out_xfer) begin
			buf_q <= {buf_q[OUT_BYTES*BYTE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
		end
	end

	// ----------------------------------------------------------- assertions
	`HCBP_ASSERT(a_buf_cnt_range, clk, arst_n, buf_cnt_q <= BCNT_W'(OUT_BYTES))
	`HCBP_ASSERT(a_pend_clean, clk, arst_n, (pend_bits_q >> pend_cnt_q) == '0)
	`HCBP_ASSERT(a_load_when_free, clk, arst_n, load_buf |-> buf_free)
	`HCBP_ASSERT(a_flush_empties, clk, arst_n, (adv && cmd_s1 == CMD_FLUSH) |=> (pend_cnt_q == '0))
	`HCBP_ASSERT_NEVER(a_no_byte_lost, clk, arst_n, load_buf && buf_cnt_q > BCNT_W'(1))

endmodule
